// ----- src/stereo_paint_mix_accumulator_assert.svh -----
// assertion macros for the stereo paint mix accumulator
`ifndef STEREO_PAINT_MIX_ACCUMULATOR_ASSERT_SVH
`define STEREO_PAINT_MIX_ACCUMULATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define STPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define STPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/stpm_pkg.sv -----
// shared types and constants of the stereo paint mix accumulator
package stpm_pkg;

   localparam int SLOT_W              = 9;
   localparam int ACC_W               = 32;
   localparam int SAMPLE_W            = 16;
   localparam int BYTE_W              = 8;
   localparam int GAIN_W              = 8;
   localparam int MASTER_W            = 10;
   localparam int GPROD_W             = GAIN_W + MASTER_W;
   localparam int FRAC_W              = 8;
   localparam int OUT_W               = 16;
   localparam int STORE_DEPTH_DEFAULT = 512;

   localparam logic [MASTER_W-1:0] MASTER_RESET = MASTER_W'(256);

   localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MIX16 = 2'd1,
      OP_MIX8  = 2'd2,
      OP_DRAIN = 2'd3
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [SLOT_W-1:0]          slot_index;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [GAIN_W-1:0]          left_gain;
      logic [GAIN_W-1:0]          right_gain;
      logic signed [ACC_W-1:0]    load_left;
      logic signed [ACC_W-1:0]    load_right;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_left;
      logic signed [OUT_W-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] left;
      logic signed [ACC_W-1:0] right;
   } acc_pair_type;

endpackage

// ----- src/stpm_store.sv -----
// accumulator store: one write port, one registered read port
module stpm_store import stpm_pkg::*; #(
   parameter int DEPTH = STORE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(STORE_DEPTH_DEFAULT)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output acc_pair_type     rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  acc_pair_type     wr_data
);

   acc_pair_type mem [DEPTH];
   acc_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/stpm_delta.sv -----
// gain-scaled sample increment for one side
module stpm_delta import stpm_pkg::*; (
   input  op_type                     op,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [GPROD_W-1:0]         gain_prod,
   output logic signed [ACC_W-1:0]    delta
);

   logic signed [SAMPLE_W-1:0]  mul_a;
   logic signed [GPROD_W:0]     mul_b;
   logic signed [SAMPLE_W+GPROD_W:0] prod;
   logic signed [SAMPLE_W+GPROD_W:0] prod_shr;

   // mix8 takes the low byte as signed and drops the gain fraction first
   always_comb begin
      if (op == OP_MIX8) begin
         mul_a = SAMPLE_W'(signed'(sample[BYTE_W-1:0]));
         mul_b = signed'((GPROD_W+1)'(gain_prod >> FRAC_W));
      end else begin
         mul_a = sample;
         mul_b = signed'((GPROD_W+1)'(gain_prod));
      end
   end

   assign prod     = mul_a * mul_b;
   assign prod_shr = prod >>> FRAC_W;

   always_comb begin
      if (op == OP_MIX8) begin
         delta = ACC_W'(prod);
      end else begin
         delta = ACC_W'(prod_shr);
      end
   end

endmodule

// ----- src/stpm_scale.sv -----
// master-volume scaling and 16-bit saturation of one drained side
module stpm_scale import stpm_pkg::*; (
   input  logic signed [ACC_W-1:0]  acc,
   input  logic [MASTER_W-1:0]      master,
   output logic signed [OUT_W-1:0]  sat_out
);

   logic signed [ACC_W+MASTER_W:0] prod;
   logic signed [ACC_W+MASTER_W:0] prod_shr;

   assign prod     = acc * signed'((MASTER_W+1)'(master));
   assign prod_shr = prod >>> FRAC_W;

   always_comb begin
      if (prod_shr > SAT_MAX) begin
         sat_out = SAT_MAX;
      end else if (prod_shr < SAT_MIN) begin
         sat_out = SAT_MIN;
      end else begin
         sat_out = OUT_W'(prod_shr);
      end
   end

endmodule

// ----- src/stpm_outq.sv -----
// small result queue between the pipeline and the result channel
module stpm_outq import stpm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_type            push_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   output logic [OUTQ_CW-1:0] count
);

   rsp_type             mem_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]  wr_ptr_ff;
   logic [OUTQ_AW-1:0]  rd_ptr_ff;
   logic [OUTQ_CW-1:0]  count_ff;
   logic [OUTQ_CW-1:0]  count_in;
   logic                pop;

   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + OUTQ_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUTQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUTQ_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUTQ_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- src/stereo_paint_mix_accumulator.sv -----
// top level of the stereo paint mix accumulator
// a drain result is offered once its request beat has passed stage 1 and stage 2
// throughput: one request beat per cycle while intake is not paused; the accumulator store
//   does one read at accept and one write-back from stage 2, with forwarding covering the gap
// intake pauses while queued results plus drains in flight fill the 4-entry queue
// reset (synchronous): clears pipeline, result queue, sets master volume to unity;
//   store contents stay undefined until written, no clearing pass
`include "stereo_paint_mix_accumulator_assert.svh"

module stereo_paint_mix_accumulator import stpm_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   // master volume write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MASTER_W-1:0] csr_data
);

   localparam int AW = $clog2(STORE_DEPTH);

   // control
   logic                run_ff;
   logic [MASTER_W-1:0] master_ff;
   logic                req_accept;
   logic                slot_ok;
   logic [AW-1:0]       addr_in;
   logic [GPROD_W-1:0]  gl_in;
   logic [GPROD_W-1:0]  gr_in;

   // stage 1: store read in flight, increment computed
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic                s1_ok_ff;
   logic [AW-1:0]       s1_addr_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [GPROD_W-1:0]  s1_gl_ff;
   logic [GPROD_W-1:0]  s1_gr_ff;
   acc_pair_type        s1_load_ff;
   acc_pair_type        s1_delta;
   acc_pair_type        rd_data;
   acc_pair_type        s1_acc_in;

   // stage 2: write-back and drain scaling
   logic                s2_valid_ff;
   op_type              s2_op_ff;
   logic                s2_ok_ff;
   logic [AW-1:0]       s2_addr_ff;
   acc_pair_type        s2_delta_ff;
   acc_pair_type        s2_load_ff;
   acc_pair_type        s2_acc_ff;
   logic                s2_wr_en;
   acc_pair_type        s2_wr_data;
   logic signed [OUT_W-1:0] scaled_left;
   logic signed [OUT_W-1:0] scaled_right;
   logic                s2_push;
   rsp_type             s2_rsp;

   // last write, covers the write that lands on the same edge as a read
   logic                lw_valid_ff;
   logic [AW-1:0]       lw_addr_ff;
   acc_pair_type        lw_data_ff;

   // result queue credit
   logic [OUTQ_CW-1:0]  q_count;
   logic                s1_drain;
   logic                s2_drain;
   logic [OUTQ_CW:0]    credit_use;

   // ---------------------------------------------------------------- config
   assign csr_ready = run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         master_ff <= MASTER_RESET;
      end else begin
         run_ff <= 1'b1;
         if (csr_valid && csr_ready) begin
            master_ff <= csr_data;
         end
      end
   end

   // ---------------------------------------------------------------- intake
   // a request beat is held off while a drain could find no room in the queue
   assign s1_drain   = s1_valid_ff && (s1_op_ff == OP_DRAIN);
   assign s2_drain   = s2_valid_ff && (s2_op_ff == OP_DRAIN);
   assign credit_use = (OUTQ_CW+1)'(q_count) + (OUTQ_CW+1)'(s1_drain)
                     + (OUTQ_CW+1)'(s2_drain);
   assign req_stall  = !run_ff || (credit_use >= (OUTQ_CW+1)'(OUTQ_DEPTH));
   assign req_accept = req_valid && !req_stall;

   // slots past the store are dropped for load and mix, read as zero for drain
   assign slot_ok = 32'(req_data.slot_index) < 32'(STORE_DEPTH);
   assign addr_in = AW'(req_data.slot_index);

   // gain times master, first of the two mix multiplies
   assign gl_in = GPROD_W'(req_data.left_gain) * GPROD_W'(master_ff);
   assign gr_in = GPROD_W'(req_data.right_gain) * GPROD_W'(master_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff         <= req_data.op;
         s1_ok_ff         <= slot_ok;
         s1_addr_ff       <= addr_in;
         s1_sample_ff     <= req_data.sample_value;
         s1_gl_ff         <= gl_in;
         s1_gr_ff         <= gr_in;
         s1_load_ff.left  <= req_data.load_left;
         s1_load_ff.right <= req_data.load_right;
      end
   end

   stpm_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (addr_in),
      .rd_data (rd_data),
      .wr_en   (s2_wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_wr_data)
   );

   // ---------------------------------------------------------------- stage 1
   stpm_delta u_delta_left (
      .op        (s1_op_ff),
      .sample    (s1_sample_ff),
      .gain_prod (s1_gl_ff),
      .delta     (s1_delta.left)
   );

   stpm_delta u_delta_right (
      .op        (s1_op_ff),
      .sample    (s1_sample_ff),
      .gain_prod (s1_gr_ff),
      .delta     (s1_delta.right)
   );

   // forwarding: the write-back now in stage 2 is newest, then the write that
   // landed on the read edge, otherwise the store read is current
   always_comb begin
      if (s2_wr_en && (s2_addr_ff == s1_addr_ff)) begin
         s1_acc_in = s2_wr_data;
      end else if (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) begin
         s1_acc_in = lw_data_ff;
      end else begin
         s1_acc_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_op_ff    <= s1_op_ff;
         s2_ok_ff    <= s1_ok_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_delta_ff <= s1_delta;
         s2_load_ff  <= s1_load_ff;
         s2_acc_ff   <= s1_acc_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // accumulators wrap modulo 2^32
   assign s2_wr_en = s2_valid_ff && s2_ok_ff && (s2_op_ff != OP_DRAIN);

   always_comb begin
      case (s2_op_ff)
         OP_LOAD: begin
            s2_wr_data = s2_load_ff;
         end
         default: begin
            s2_wr_data.left  = s2_acc_ff.left + s2_delta_ff.left;
            s2_wr_data.right = s2_acc_ff.right + s2_delta_ff.right;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= s2_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_wr_en) begin
         lw_addr_ff <= s2_addr_ff;
         lw_data_ff <= s2_wr_data;
      end
   end

   // drain: acc times master, shift down, saturate to 16 bits
   stpm_scale u_scale_left (
      .acc     (s2_acc_ff.left),
      .master  (master_ff),
      .sat_out (scaled_left)
   );

   stpm_scale u_scale_right (
      .acc     (s2_acc_ff.right),
      .master  (master_ff),
      .sat_out (scaled_right)
   );

   assign s2_push = s2_drain;

   always_comb begin
      if (s2_ok_ff) begin
         s2_rsp.out_left  = scaled_left;
         s2_rsp.out_right = scaled_right;
      end else begin
         s2_rsp.out_left  = '0;
         s2_rsp.out_right = '0;
      end
   end

   // ---------------------------------------------------------------- results
   stpm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_push),
      .push_data (s2_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   // ---------------------------------------------------------------- checks
   // queued results plus drains in flight never exceed the queue
   `STPM_ASSERT_NOW(a_credit_bound, clock, reset, 1'b1, credit_use <= (OUTQ_CW+1)'(OUTQ_DEPTH), "result queue overcommitted")
   // back-to-back hits on one slot pick up the value being written back
   `STPM_ASSERT_NEXT(a_forward_hit, clock, reset, s2_wr_en && s1_valid_ff && (s2_addr_ff == s1_addr_ff), s2_acc_ff == $past(s2_wr_data), "forwarded accumulator lost")
   // an accepted drain beat moves into stage 1
   `STPM_ASSERT_NEXT(a_drain_enter, clock, reset, req_accept && (req_data.op == OP_DRAIN), s1_valid_ff && (s1_op_ff == OP_DRAIN), "drain beat dropped at intake")
   // a drain leaving stage 2 is offered on the result channel
   `STPM_ASSERT_NEXT(a_drain_offer, clock, reset, s2_push, rsp_valid, "drain result not offered")

endmodule

// ----- dv/paint_mix_checker.sv -----
// checker for the stereo paint mix accumulator: watches all channels, predicts drains, compares
module paint_mix_checker import stpm_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_type             rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [MASTER_W-1:0] csr_data,
   output int                  fail_count,
   output int                  outstanding
);

   logic [ACC_W-1:0]    acc_left  [STORE_DEPTH];
   logic [ACC_W-1:0]    acc_right [STORE_DEPTH];
   logic [MASTER_W-1:0] master_vol;
   rsp_type             drains_due[$];
   int                  mismatches = 0;

   // gain-scaled increment for one side, wrapped to accumulator width
   function automatic logic [ACC_W-1:0] mix_increment(req_type beat, logic [GAIN_W-1:0] gain);
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [BYTE_W-1:0]   smp8;
      longint                     s, g, mv, d;
      smp  = beat.sample_value;
      smp8 = beat.sample_value[BYTE_W-1:0];
      g    = gain;
      mv   = master_vol;
      if (beat.op == OP_MIX16) begin
         s = smp;
         d = (s * (g * mv)) >>> FRAC_W;
      end else begin
         s = smp8;
         d = s * ((g * mv) >>> FRAC_W);
      end
      return d[ACC_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] drained_side(logic [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] a;
      longint                  p, mv;
      a  = acc;
      p  = a;
      mv = master_vol;
      p  = (p * mv) >>> FRAC_W;
      if (p > longint'(SAT_MAX))
         return SAT_MAX;
      if (p < longint'(SAT_MIN))
         return SAT_MIN;
      return p[OUT_W-1:0];
   endfunction

   task automatic apply_beat(req_type beat);
      rsp_type r;
      logic    slot_ok;
      slot_ok = beat.slot_index < STORE_DEPTH;
      case (beat.op)
         OP_LOAD: begin
            if (slot_ok) begin
               acc_left[beat.slot_index]  = beat.load_left;
               acc_right[beat.slot_index] = beat.load_right;
            end
         end
         OP_MIX16, OP_MIX8: begin
            if (slot_ok) begin
               acc_left[beat.slot_index]  = acc_left[beat.slot_index]
                                            + mix_increment(beat, beat.left_gain);
               acc_right[beat.slot_index] = acc_right[beat.slot_index]
                                            + mix_increment(beat, beat.right_gain);
            end
         end
         default: begin
            r = '0;
            if (slot_ok) begin
               r.out_left  = drained_side(acc_left[beat.slot_index]);
               r.out_right = drained_side(acc_right[beat.slot_index]);
            end
            drains_due.push_back(r);
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         master_vol = MASTER_RESET;
         drains_due.delete();
      end else begin
         // result side first: a beat leaving now belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (drains_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected drain beat, expected none, actual %0d %0d",
                        $time, rsp_data.out_left, rsp_data.out_right);
            end else begin
               want = drains_due.pop_front();
               if (rsp_data.out_left !== want.out_left) begin
                  mismatches++;
                  $display("%0t: out_left expected %0d actual %0d",
                           $time, want.out_left, rsp_data.out_left);
               end
               if (rsp_data.out_right !== want.out_right) begin
                  mismatches++;
                  $display("%0t: out_right expected %0d actual %0d",
                           $time, want.out_right, rsp_data.out_right);
               end
            end
         end
         if (csr_valid && csr_ready)
            master_vol = csr_data;
         if (req_valid && !req_stall)
            apply_beat(req_data);
      end
      fail_count  <= mismatches;
      outstanding <= drains_due.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the stereo paint mix accumulator: stimulus, flow control and verdict
module tb_top;
   import stpm_pkg::*;

   // run ends here no matter what; far above the slowest legal run
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 180;
   localparam int HOT_SLOTS    = 8;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 80;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [MASTER_W-1:0] csr_data;

   int fail_count;
   int outstanding;
   int cycle_count  = 0;
   int idle_pct     = 0;
   bit hold_request = 1'b0;

   // slots that hold a defined value; only these may be mixed into or drained
   bit slot_loaded [STORE_DEPTH_DEFAULT];
   int loaded_slots[$];

   stereo_paint_mix_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   paint_mix_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request so the
   // result queue fills and the block has to push back on its request side
   initial begin : drain_side_flow
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request beat: optional sender gap, then hold the payload until taken
   task send_item(input req_type beat);
      if (beat.op == OP_LOAD && !slot_loaded[beat.slot_index]) begin
         slot_loaded[beat.slot_index] = 1'b1;
         loaded_slots.push_back(int'(beat.slot_index));
      end
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task issue_op(input op_type op, input logic [SLOT_W-1:0] slot,
                 input logic [SAMPLE_W-1:0] smp, input logic [GAIN_W-1:0] lg,
                 input logic [GAIN_W-1:0] rg, input logic [ACC_W-1:0] ll,
                 input logic [ACC_W-1:0] lr);
      req_type beat;
      beat.op           = op;
      beat.slot_index   = slot;
      beat.sample_value = smp;
      beat.left_gain    = lg;
      beat.right_gain   = rg;
      beat.load_left    = ll;
      beat.load_right   = lr;
      send_item(beat);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [ACC_W-1:0] pick_load();
      logic signed [SAMPLE_W-1:0] modest;
      logic signed [ACC_W-1:0]    wide;
      // half full-range values (mostly saturate on drain), half modest ones
      if ($urandom_range(0, 1) == 0)
         return $urandom;
      modest = SAMPLE_W'($urandom);
      wide   = modest;
      return wide;
   endfunction

   // random beat; mixes and drains land on loaded slots only, and mostly on a
   // small hot set so back-to-back hazards on one slot happen often
   task build_random(output req_type beat);
      int r;
      int hot;
      beat = '0;
      r    = $urandom_range(0, 99);
      if (r < 20 || loaded_slots.size() == 0) begin
         beat.op         = OP_LOAD;
         beat.slot_index = ($urandom_range(0, 1) == 0)
                         ? SLOT_W'($urandom_range(0, HOT_SLOTS - 1))
                         : SLOT_W'($urandom_range(0, STORE_DEPTH_DEFAULT - 1));
      end else begin
         beat.op = (r < 50) ? OP_MIX16 : (r < 72) ? OP_MIX8 : OP_DRAIN;
         hot     = $urandom_range(0, HOT_SLOTS - 1);
         if ($urandom_range(0, 2) != 0 && slot_loaded[hot])
            beat.slot_index = SLOT_W'(hot);
         else
            beat.slot_index =
               SLOT_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
      end
      case ($urandom_range(0, 9))
         0:       beat.sample_value = 16'sh8000;
         1:       beat.sample_value = 16'sh7fff;
         default: beat.sample_value = SAMPLE_W'($urandom);
      endcase
      beat.left_gain  = pick_gain();
      beat.right_gain = pick_gain();
      beat.load_left  = pick_load();
      beat.load_right = pick_load();
   endtask

   // master volume may only change while nothing is in flight
   task write_master(input logic [MASTER_W-1:0] vol);
      csr_data  <= vol;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait until every drain has come back, then let write-backs of
   // loads and mixes clear the pipeline
   task settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      req_type             beat;
      logic [MASTER_W-1:0] vol;
      int                  ph;
      int                  n;
      int                  phase_idle [PHASES];

      phase_idle = '{25, 40, 0, 15, 30, 25, 40, 0};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset master volume (unity)
      idle_pct = 20;
      // full-scale accumulators saturate both ways
      issue_op(OP_LOAD,  9'd0,   16'h0000, 8'd0,   8'd0,   32'h7fffffff, 32'h80000000);
      issue_op(OP_DRAIN, 9'd0,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      // top slot, extreme samples and gains for the 16-bit mix
      issue_op(OP_LOAD,  9'd511, 16'hffff, 8'd255, 8'd255, 32'h0,        32'h0);
      issue_op(OP_MIX16, 9'd511, 16'h8000, 8'd255, 8'd0,   32'hffffffff, 32'hffffffff);
      issue_op(OP_MIX16, 9'd511, 16'h7fff, 8'd0,   8'd255, 32'h0,        32'h0);
      issue_op(OP_DRAIN, 9'd511, 16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      // 8-bit mix with the extreme bytes and junk in the upper byte
      issue_op(OP_MIX8,  9'd511, 16'h7f80, 8'd255, 8'd255, 32'h0,        32'h0);
      issue_op(OP_MIX8,  9'd511, 16'h807f, 8'd1,   8'd128, 32'h0,        32'h0);
      issue_op(OP_DRAIN, 9'd511, 16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      // accumulator wraps past the positive limit
      issue_op(OP_LOAD,  9'd1,   16'h0000, 8'd0,   8'd0,   32'h7fffff00, 32'hffffffff);
      issue_op(OP_MIX16, 9'd1,   16'h7fff, 8'd255, 8'd255, 32'h0,        32'h0);
      issue_op(OP_DRAIN, 9'd1,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      // small values pass unsaturated
      issue_op(OP_LOAD,  9'd2,   16'h0000, 8'd0,   8'd0,   32'd100,      32'hffffff9c);
      issue_op(OP_DRAIN, 9'd2,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      issue_op(OP_LOAD,  9'd3,   16'h0000, 8'd0,   8'd0,   32'hffffffff, 32'd1);
      issue_op(OP_DRAIN, 9'd3,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      // back-to-back read-modify-write on one slot exercises forwarding
      issue_op(OP_LOAD,  9'd4,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      issue_op(OP_MIX16, 9'd4,   16'd1000, 8'd16,  8'd200, 32'h0,        32'h0);
      issue_op(OP_MIX16, 9'd4,   16'hfffb, 8'd77,  8'd3,   32'h0,        32'h0);
      issue_op(OP_MIX8,  9'd4,   16'h00ff, 8'd255, 8'd9,   32'h0,        32'h0);
      issue_op(OP_DRAIN, 9'd4,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      issue_op(OP_LOAD,  9'd4,   16'h0000, 8'd0,   8'd0,   32'd5,        32'hfffffffb);
      issue_op(OP_DRAIN, 9'd4,   16'h0000, 8'd0,   8'd0,   32'h0,        32'h0);
      settle_idle();

      // random phases, each under its own master volume; extremes included
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       vol = MASTER_W'(256);
            1:       vol = '1;
            2:       vol = '0;
            3:       vol = MASTER_W'(1);
            4:       vol = MASTER_W'(512);
            5:       vol = MASTER_W'($urandom_range(2, 1022));
            6:       vol = MASTER_W'(700);
            default: vol = MASTER_W'(256);
         endcase
         write_master(vol);
         idle_pct = phase_idle[ph];
         // long receiver hold-off while the sender keeps pushing
         if (ph == 3)
            hold_request = 1'b1;
         for (n = 0; n < PHASE_BEATS; n++) begin
            build_random(beat);
            send_item(beat);
         end
         settle_idle();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/stpm_pkg.sv
src/stpm_store.sv
src/stpm_delta.sv
src/stpm_scale.sv
src/stpm_outq.sv
src/stereo_paint_mix_accumulator.sv
dv/paint_mix_checker.sv
dv/tb_top.sv
